FILE: src/bffa_pkg.sv
// Shared constants for the bitmap first-fit block allocator.
`default_nettype none
package bffa_pkg;

	localparam int WORD_BITS  = 8;
	localparam int WORD_SHIFT = 3;
	localparam int COUNT_W    = 11;
	localparam int START_W    = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		STAT_DONE    = 1'b0,
		STAT_NOSPACE = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

FILE: src/bffa_map_ram.sv
// Usage map storage: one write port, one registered read port.
`default_nettype none
module bffa_map_ram import bffa_pkg::*; #(
	parameter int WORDS = 128,
	parameter int AW    = 7
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/bffa_scan.sv
// First-fit run search over one map word per cycle.
`default_nettype none
module bffa_scan import bffa_pkg::*; #(
	parameter int MEMORY_BLOCKS = 1024,
	parameter int AW            = 7,
	parameter int PW            = 11
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 init,
	input  wire logic                 word_valid,
	input  wire logic [AW-1:0]        word_addr,
	input  wire logic [WORD_BITS-1:0] word_data,
	input  wire logic [COUNT_W-1:0]   count,
	output logic                      hit,
	output logic      [PW-1:0]        hit_start
);

	localparam int SW = PW + 1;

	logic [PW-1:0] run_start_q;
	logic [PW-1:0] rs;
	logic [PW-1:0] pos;
	logic [SW-1:0] need;
	logic          used;

	// run start is the block after the last used one; a run ends at pos when
	// pos + 1 == run start + count
	always_comb begin
		rs        = run_start_q;
		hit       = 1'b0;
		hit_start = '0;
		need      = '0;
		pos       = '0;
		used      = 1'b0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pos  = {1'b0, word_addr, WORD_SHIFT'(j)};
			used = word_data[j] || (pos >= PW'(MEMORY_BLOCKS));
			need = SW'(rs) + SW'(count);
			if (!used && !hit && (SW'(pos) + SW'(1) == need)) begin
				hit       = word_valid;
				hit_start = rs;
			end
			if (used) begin
				rs = pos + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= '0;
		end else if (init) begin
			run_start_q <= '0;
		end else if (word_valid) begin
			run_start_q <= rs;
		end
	end

endmodule
`default_nettype wire

FILE: src/bitmap_first_fit_allocator_unit.sv
// Bitmap first-fit allocator top level: control, range update and output register.
// After reset a clearing pass writes every map word and no item is taken until it ends.
// An allocate scans map words up to the hit (W words) and then marks R words; a failed
// allocate scans every word; a free marks R words; zero or oversized allocate and empty
// free go straight to the result. One map word is read per cycle.
// The next item can be taken in the cycle after the result enters its register.
`default_nettype none
module bitmap_first_fit_allocator_unit import bffa_pkg::*; #(
	parameter int MEMORY_BLOCKS = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// block_count [10:0], start_block [20:11], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// mode [0]
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// found_start [9:0], zero pad
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	// status [0]
	output logic      [0:0]            m_axis_tuser
);

	localparam int NW = (MEMORY_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = $clog2(NW);
	localparam int PW = AW + WORD_SHIFT + 1;
	localparam int XW = (PW > 12) ? PW : 12;

	state_t state_q, state_d;

	logic [AW-1:0]        addr_q;
	logic                 issue_q;
	logic                 rd_valid_s1;
	logic [AW-1:0]        addr_s1;
	logic                 op_q;
	logic [COUNT_W-1:0]   count_q;
	logic [PW-1:0]        lo_q, hi_q;
	logic [AW-1:0]        last_q;
	logic                 rstat_q;
	logic [START_W-1:0]   rfound_q;
	logic                 out_valid_q;
	logic                 out_stat_q;
	logic [START_W-1:0]   out_found_q;

	logic                 accept;
	logic                 in_mode;
	logic [COUNT_W-1:0]   in_count;
	logic [START_W-1:0]   in_start;
	logic [PW-1:0]        in_pos;
	logic [XW-1:0]        in_end;
	logic [XW-1:0]        in_end_clip;
	logic [XW-1:0]        hit_end;
	logic                 alloc_zero, alloc_big, free_none;
	logic                 re, we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata, rdata, mask;
	logic [PW-1:0]        pos;
	logic                 hit;
	logic [PW-1:0]        hit_start;
	logic                 scan_miss, mark_done, resp_go;

	assign in_mode  = s_axis_tuser[0];
	assign in_count = s_axis_tdata[COUNT_W-1:0];
	assign in_start = s_axis_tdata[COUNT_W+START_W-1:COUNT_W];
	assign in_pos   = PW'(in_start);
	assign accept   = s_axis_tvalid && s_axis_tready;

	assign in_end      = XW'(in_start) + XW'(in_count);
	assign in_end_clip = (in_end > XW'(MEMORY_BLOCKS)) ? XW'(MEMORY_BLOCKS) : in_end;
	assign hit_end     = XW'(hit_start) + XW'(count_q);
	assign alloc_zero  = (in_count == '0);
	assign alloc_big   = XW'(in_count) > XW'(MEMORY_BLOCKS);
	assign free_none   = (in_count == '0) || (XW'(in_start) >= XW'(MEMORY_BLOCKS));

	assign scan_miss = (state_q == ST_SCAN) && rd_valid_s1 && !hit
	                   && (addr_s1 == AW'(NW - 1));
	assign mark_done = (state_q == ST_MARK) && rd_valid_s1 && (addr_s1 == last_q);
	assign resp_go   = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

	bffa_map_ram #(
		.WORDS (NW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (addr_q),
		.rdata (rdata)
	);

	bffa_scan #(
		.MEMORY_BLOCKS (MEMORY_BLOCKS),
		.AW            (AW),
		.PW            (PW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.init       (accept),
		.word_valid (rd_valid_s1 && (state_q == ST_SCAN)),
		.word_addr  (addr_s1),
		.word_data  (rdata),
		.count      (count_q),
		.hit        (hit),
		.hit_start  (hit_start)
	);

	// bits of the word being rewritten that fall in [lo, hi)
	always_comb begin
		mask = '0;
		pos  = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pos     = {1'b0, addr_s1, WORD_SHIFT'(j)};
			mask[j] = (pos >= lo_q) && (pos < hi_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == AW'(NW - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_mode == OP_FREE) begin
						state_d = free_none ? ST_RESP : ST_MARK;
					end else begin
						state_d = (alloc_zero || alloc_big) ? ST_RESP : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) state_d = ST_MARK;
				else if (scan_miss) state_d = ST_RESP;
			end
			ST_MARK: begin
				if (mark_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_go) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		re            = 1'b0;
		we            = 1'b0;
		waddr         = addr_s1;
		wdata         = (op_q == OP_FREE) ? (rdata & ~mask) : (rdata | mask);
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = addr_q;
				wdata = '0;
			end
			ST_SCAN:  re = issue_q && !hit;
			ST_MARK: begin
				re = issue_q;
				we = rd_valid_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= re;
			if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + AW'(1);
			end else if (accept) begin
				addr_q  <= (in_mode == OP_FREE) ? in_pos[AW+WORD_SHIFT-1:WORD_SHIFT] : '0;
				issue_q <= 1'b1;
			end else if ((state_q == ST_SCAN) && hit) begin
				addr_q  <= hit_start[AW+WORD_SHIFT-1:WORD_SHIFT];
				issue_q <= 1'b1;
			end else if (re) begin
				addr_q <= addr_q + AW'(1);
				if (((state_q == ST_SCAN) && (addr_q == AW'(NW - 1)))
				    || ((state_q == ST_MARK) && (addr_q == last_q))) begin
					issue_q <= 1'b0;
				end
			end
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and range bounds
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept) begin
			op_q     <= in_mode;
			count_q  <= in_count;
			rstat_q  <= (in_mode == OP_ALLOC && alloc_big) ? STAT_NOSPACE : STAT_DONE;
			rfound_q <= '0;
			lo_q     <= in_pos;
			hi_q     <= PW'(in_end_clip);
			last_q   <= AW'((in_end_clip - XW'(1)) >> WORD_SHIFT);
		end else if ((state_q == ST_SCAN) && hit) begin
			lo_q     <= hit_start;
			hi_q     <= PW'(hit_end);
			last_q   <= AW'((hit_end - XW'(1)) >> WORD_SHIFT);
			rfound_q <= START_W'(hit_start);
		end else if (scan_miss) begin
			rstat_q <= STAT_NOSPACE;
		end
		if (resp_go) begin
			out_stat_q  <= rstat_q;
			out_found_q <= rfound_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-START_W){1'b0}}, out_found_q};
	assign m_axis_tuser  = out_stat_q;

endmodule
`default_nettype wire
